FILE: sv/pee_pkg.sv
`default_nettype none

package pee_pkg;

    localparam int STACK_DEPTH_DEF = 10;

    // Operator codes shared by the sequencer and the float unit
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    // Status codes reported with each result word
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_FEW      = 3'd2,
        ST_DIVZERO  = 3'd3,
        ST_NOTOKEN  = 3'd4,
        ST_EXTRA    = 3'd5
    } t_status;

    // Request from the sequencer to the float unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_fpu_req;

    localparam logic [31:0] ERR_VALUE = 32'hC479C000;
    localparam logic [31:0] QNAN_DEF  = 32'hFFC00000;
    localparam logic [31:0] QNAN_BIT  = 32'h00400000;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Single-precision pattern of a decimal digit
    function automatic logic [31:0] digit_to_float(input logic [3:0] d);
        logic [31:0] f;
        case (d)
            4'd1:    f = 32'h3F800000;
            4'd2:    f = 32'h40000000;
            4'd3:    f = 32'h40400000;
            4'd4:    f = 32'h40800000;
            4'd5:    f = 32'h40A00000;
            4'd6:    f = 32'h40C00000;
            4'd7:    f = 32'h40E00000;
            4'd8:    f = 32'h41000000;
            4'd9:    f = 32'h41100000;
            default: f = 32'h00000000;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: sv/pee_stack.sv
`default_nettype none

module pee_stack
    import pee_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/pee_fpu.sv
`default_nettype none

module pee_fpu
    import pee_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_fpu_req    i_req,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [31:0]      o_result
);

    typedef enum logic [3:0] {
        F_IDLE,
        F_PRE,
        F_ALIGN,
        F_ADD,
        F_MUL,
        F_DIV,
        F_NORM,
        F_DENORM,
        F_ROUND,
        F_DONE
    } t_fstate;

    t_fstate            r_state;
    t_op                r_op;
    logic               r_sa;
    logic               r_sb;
    logic               r_sign;
    logic signed [10:0] r_ea;
    logic signed [10:0] r_eb;
    logic signed [10:0] r_x;
    logic [23:0]        r_ma;
    logic [23:0]        r_mb;
    logic [49:0]        r_m;
    logic [49:0]        r_sml;
    logic [7:0]         r_d;
    logic [24:0]        r_rem;
    logic [26:0]        r_q;
    logic [4:0]         r_cnt;
    logic [31:0]        r_res;

    // Operand unpacking
    logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, sbe, b_gt;
    logic [7:0]  a_ee, b_ee;
    logic [23:0] a_mm, b_mm;

    assign a_nan  = (&i_a[30:23]) && (|i_a[22:0]);
    assign a_inf  = (&i_a[30:23]) && !(|i_a[22:0]);
    assign a_zero = (i_a[30:0] == 31'd0);
    assign b_nan  = (&i_b[30:23]) && (|i_b[22:0]);
    assign b_inf  = (&i_b[30:23]) && !(|i_b[22:0]);
    assign b_zero = (i_b[30:0] == 31'd0);
    assign a_ee   = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
    assign b_ee   = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
    assign a_mm   = {|i_a[30:23], i_a[22:0]};
    assign b_mm   = {|i_b[30:23], i_b[22:0]};
    assign sbe    = i_b[31] ^ (i_req.op == OP_SUB);
    assign b_gt   = (b_ee > a_ee);

    // Special operands settle the result at once
    logic        sp_hit;
    logic [31:0] sp_val;
    logic        ps;

    always_comb begin
        sp_hit = 1'b1;
        sp_val = QNAN_DEF;
        ps     = i_a[31] ^ i_b[31];
        if (a_nan) begin
            sp_val = i_a | QNAN_BIT;
        end else if (b_nan) begin
            sp_val = i_b | QNAN_BIT;
        end else begin
            unique case (i_req.op)
                OP_ADD, OP_SUB: begin
                    priority if (a_inf && b_inf) begin
                        sp_val = (i_a[31] == sbe) ? i_a : QNAN_DEF;
                    end else if (a_inf) begin
                        sp_val = i_a;
                    end else if (b_inf) begin
                        sp_val = {sbe, 8'hFF, 23'd0};
                    end else begin
                        sp_hit = 1'b0;
                    end
                end
                OP_MUL: begin
                    priority if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                        sp_val = QNAN_DEF;
                    end else if (a_inf || b_inf) begin
                        sp_val = {ps, 8'hFF, 23'd0};
                    end else if (a_zero || b_zero) begin
                        sp_val = {ps, 31'd0};
                    end else begin
                        sp_hit = 1'b0;
                    end
                end
                OP_DIV: begin
                    priority if ((a_inf && b_inf) || (a_zero && b_zero)) begin
                        sp_val = QNAN_DEF;
                    end else if (a_inf || b_zero) begin
                        sp_val = {ps, 8'hFF, 23'd0};
                    end else if (b_inf || a_zero) begin
                        sp_val = {ps, 31'd0};
                    end else begin
                        sp_hit = 1'b0;
                    end
                end
            endcase
        end
    end

    // Magnitude add or subtract
    logic        eff_sub, mag_ge;
    logic [49:0] add_res;
    logic        add_sign;

    assign eff_sub = r_sa ^ r_sb;
    assign mag_ge  = (r_m >= r_sml);

    always_comb begin
        if (!eff_sub) begin
            add_res  = r_m + r_sml;
            add_sign = r_sa;
        end else if (mag_ge) begin
            add_res  = r_m - r_sml;
            add_sign = r_sa;
        end else begin
            add_res  = r_sml - r_m;
            add_sign = r_sb;
        end
    end

    // Multiplier
    logic [47:0] prod;
    assign prod = r_ma * r_mb;

    // One restoring division step
    logic        div_ge;
    logic [24:0] rem2;
    logic [26:0] q_nxt;

    assign div_ge = (r_rem >= {1'b0, r_mb});
    assign rem2   = div_ge ? (r_rem - {1'b0, r_mb}) : r_rem;
    assign q_nxt  = {r_q[25:0], div_ge};

    // Round to nearest even and pack
    logic               rnd_up;
    logic [24:0]        rnd;
    logic signed [10:0] x_rnd;
    logic [23:0]        man;

    assign rnd_up = r_m[25] && ((|r_m[24:0]) || r_m[26]);
    assign rnd    = {1'b0, r_m[49:26]} + {24'd0, rnd_up};
    assign x_rnd  = rnd[24] ? (r_x + 11'sd1) : r_x;
    assign man    = rnd[24] ? rnd[24:1] : rnd[23:0];

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_req.start) begin
                        r_op   <= i_req.op;
                        r_sign <= i_a[31] ^ i_b[31];
                        r_ma   <= a_mm;
                        r_mb   <= b_mm;
                        r_eb   <= {3'd0, b_ee};
                        if (sp_hit) begin
                            r_res   <= sp_val;
                            r_state <= F_DONE;
                        end else if (i_req.op == OP_ADD || i_req.op == OP_SUB) begin
                            r_sa    <= b_gt ? sbe : i_a[31];
                            r_sb    <= b_gt ? i_a[31] : sbe;
                            r_ea    <= {3'd0, (b_gt ? b_ee : a_ee)};
                            r_d     <= b_gt ? (b_ee - a_ee) : (a_ee - b_ee);
                            r_m     <= {1'b0, (b_gt ? b_mm : a_mm), 25'd0};
                            r_sml   <= {1'b0, (b_gt ? a_mm : b_mm), 25'd0};
                            r_state <= F_ALIGN;
                        end else begin
                            r_ea    <= {3'd0, a_ee};
                            r_state <= F_PRE;
                        end
                    end
                end
                // Bring subnormal mantissas to a leading one
                F_PRE: begin
                    if (!r_ma[23]) begin
                        r_ma <= {r_ma[22:0], 1'b0};
                        r_ea <= r_ea - 11'sd1;
                    end else if (!r_mb[23]) begin
                        r_mb <= {r_mb[22:0], 1'b0};
                        r_eb <= r_eb - 11'sd1;
                    end else begin
                        r_rem   <= {1'b0, r_ma};
                        r_q     <= '0;
                        r_cnt   <= 5'd26;
                        r_state <= (r_op == OP_MUL) ? F_MUL : F_DIV;
                    end
                end
                // Shift the smaller operand right, keeping a sticky bit
                F_ALIGN: begin
                    if (r_d == 8'd0) begin
                        r_state <= F_ADD;
                    end else if (r_d >= 8'd50) begin
                        r_sml <= {49'd0, |r_sml};
                        r_d   <= 8'd0;
                    end else begin
                        r_sml <= {1'b0, r_sml[49:2], r_sml[1] | r_sml[0]};
                        r_d   <= r_d - 8'd1;
                    end
                end
                F_ADD: begin
                    r_x    <= r_ea + 11'sd1;
                    r_m    <= add_res;
                    r_sign <= add_sign;
                    if (add_res == 50'd0) begin
                        r_res   <= {(eff_sub ? 1'b0 : r_sa), 31'd0};
                        r_state <= F_DONE;
                    end else begin
                        r_state <= F_NORM;
                    end
                end
                F_MUL: begin
                    r_m     <= {2'd0, prod};
                    r_x     <= r_ea + r_eb - 11'sd124;
                    r_state <= F_NORM;
                end
                F_DIV: begin
                    r_q   <= q_nxt;
                    r_rem <= {rem2[23:0], 1'b0};
                    if (r_cnt == 5'd0) begin
                        r_m     <= {q_nxt, 22'd0, |rem2};
                        r_x     <= r_ea - r_eb + 11'sd127;
                        r_state <= F_NORM;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                // Shift left until the leading one reaches the top
                F_NORM: begin
                    if (!r_m[49]) begin
                        r_m <= {r_m[48:0], 1'b0};
                        r_x <= r_x - 11'sd1;
                    end else begin
                        r_state <= F_DENORM;
                    end
                end
                // Shift right into the subnormal range
                F_DENORM: begin
                    priority if (r_x >= 11'sd1) begin
                        r_state <= F_ROUND;
                    end else if (r_x < -11'sd60) begin
                        r_m <= 50'd1;
                        r_x <= 11'sd1;
                    end else begin
                        r_m <= {1'b0, r_m[49:2], r_m[1] | r_m[0]};
                        r_x <= r_x + 11'sd1;
                    end
                end
                F_ROUND: begin
                    if (x_rnd >= 11'sd255) begin
                        r_res <= {r_sign, 8'hFF, 23'd0};
                    end else begin
                        r_res <= {r_sign, (man[23] ? x_rnd[7:0] : 8'd0), man[22:0]};
                    end
                    r_state <= F_DONE;
                end
                F_DONE: begin
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == F_DONE);
    assign o_result = r_res;

endmodule

`default_nettype wire

FILE: sv/postfix_expression_evaluator.sv
// Digits and skipped characters are taken in S_IDLE; the final character then passes S_FIN and S_OUT.
// An operator passes S_RDB, S_RDA and, unless it divides by zero, S_CALC, which waits on the float unit:
// add/sub alignment and normalisation shift one bit a cycle, and divide runs 27 quotient steps.
// One item at a time; the result register frees the input side while a word waits.
// Reset (synchronous, active low) empties the stack and clears the error and token flags.
`default_nettype none

module postfix_expression_evaluator
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_value,
    output logic [2:0]       o_status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDB,
        S_RDA,
        S_CALC,
        S_FIN,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [CW-1:0] r_count;
    t_status     r_err;
    logic        r_token;
    t_op         r_op;
    logic        r_last;
    logic [31:0] r_b;
    t_status     r_status;
    logic        r_out_valid;
    logic [31:0] r_value;
    t_status     r_out_status;

    // Character decode
    logic        is_digit, is_opr, accept, div_zero;
    t_op         sym_op;
    logic [7:0]  dig;

    assign accept   = i_valid && o_ready;
    assign is_digit = (i_symbol >= CH_ZERO) && (i_symbol <= CH_NINE);
    assign is_opr   = (i_symbol == CH_PLUS) || (i_symbol == CH_MINUS)
                   || (i_symbol == CH_STAR) || (i_symbol == CH_SLASH);
    assign dig      = i_symbol - CH_ZERO;
    assign div_zero = (r_op == OP_DIV) && (r_b[30:0] == 31'd0);

    always_comb begin
        priority if (i_symbol == CH_MINUS) begin
            sym_op = OP_SUB;
        end else if (i_symbol == CH_STAR) begin
            sym_op = OP_MUL;
        end else if (i_symbol == CH_SLASH) begin
            sym_op = OP_DIV;
        end else begin
            sym_op = OP_ADD;
        end
    end

    // Stack addressing
    logic [CW-1:0] cnt_m1, cnt_m2;
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [31:0]   st_wdata, st_rdata;
    logic          fpu_done;
    logic [31:0]   fpu_res;
    t_fpu_req      fpu_req;

    assign cnt_m1 = r_count - CW'(1);
    assign cnt_m2 = r_count - CW'(2);

    always_comb begin
        unique case (r_state)
            S_IDLE:  st_raddr = cnt_m1[AW-1:0];
            S_RDB:   st_raddr = cnt_m2[AW-1:0];
            default: st_raddr = '0;
        endcase
    end

    assign st_we = (r_state == S_IDLE && accept && r_err == ST_OK && is_digit
                    && r_count < CW'(STACK_DEPTH))
                || (r_state == S_CALC && fpu_done);
    assign st_waddr = (r_state == S_CALC) ? cnt_m2[AW-1:0] : r_count[AW-1:0];
    assign st_wdata = (r_state == S_CALC) ? fpu_res : digit_to_float(dig[3:0]);

    assign fpu_req.start = (r_state == S_RDA) && !div_zero;
    assign fpu_req.op    = r_op;

    pee_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    pee_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (fpu_req),
        .i_a      (st_rdata),
        .i_b      (r_b),
        .o_done   (fpu_done),
        .o_result (fpu_res)
    );

    // Sequencer, stack bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_token     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op   <= sym_op;
                        r_last <= i_last;
                        if (r_err == ST_OK && is_digit) begin
                            if (r_count >= CW'(STACK_DEPTH)) begin
                                r_err <= ST_OVERFLOW;
                            end else begin
                                r_count <= r_count + CW'(1);
                                r_token <= 1'b1;
                            end
                            r_state <= i_last ? S_FIN : S_IDLE;
                        end else if (r_err == ST_OK && is_opr) begin
                            if (r_count < CW'(2)) begin
                                r_err   <= ST_FEW;
                                r_state <= i_last ? S_FIN : S_IDLE;
                            end else begin
                                r_state <= S_RDB;
                            end
                        end else begin
                            r_state <= i_last ? S_FIN : S_IDLE;
                        end
                    end
                end
                // Hold the top word, fetch the one below
                S_RDB: begin
                    r_b     <= st_rdata;
                    r_state <= S_RDA;
                end
                S_RDA: begin
                    if (div_zero) begin
                        r_err   <= ST_DIVZERO;
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end else begin
                        r_state <= S_CALC;
                    end
                end
                // Pop two, push one
                S_CALC: begin
                    if (fpu_done) begin
                        r_count <= cnt_m1;
                        r_token <= 1'b1;
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    priority if (r_err != ST_OK) begin
                        r_status <= r_err;
                    end else if (!r_token) begin
                        r_status <= ST_NOTOKEN;
                    end else if (r_count == '0) begin
                        r_status <= ST_FEW;
                    end else if (r_count > CW'(1)) begin
                        r_status <= ST_EXTRA;
                    end else begin
                        r_status <= ST_OK;
                    end
                    r_state <= S_OUT;
                end
                // Load the result word once the output register is free, then clear
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_value      <= (r_status == ST_OK) ? st_rdata : ERR_VALUE;
                        r_out_status <= r_status;
                        r_out_valid  <= 1'b1;
                        r_count      <= '0;
                        r_err        <= ST_OK;
                        r_token      <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign o_status = r_out_status;

endmodule

`default_nettype wire
